>>> rtl/buffered_two_way_row_partition_assert.svh
// Assertion macros shared by the row partition RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BUFFERED_TWO_WAY_ROW_PARTITION_ASSERT_SVH
`define BUFFERED_TWO_WAY_ROW_PARTITION_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define BRP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/brp_pkg.sv
// Package for the buffered two-way row partition: row layout, buffer
// geometry, control structs and sequencer states. No dependencies.
package brp_pkg;

    localparam int WORD_W     = 32;
    localparam int DISC_W     = 7;
    localparam int SIDE_SLOTS = 32;
    localparam int IDX_W      = $clog2(SIDE_SLOTS);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int APB_ADDR_W = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [APB_ADDR_W-1:0] apb_addr_t;
    typedef logic [WORD_W-1:0]     word_t;

    // Register byte addresses
    localparam apb_addr_t REG_MATCH_BRAND = 2'd0;

    typedef struct packed {
        word_t             brand;
        word_t             container;
        word_t             quantity;
        word_t             price;
        logic [DISC_W-1:0] discount;
    } row_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        logic  rd_en;
        addr_t rd_addr;
    } mem_ctl_t;

    typedef struct packed {
        logic load;
        logic last;
        logic from_match;
    } out_ctl_t;

endpackage

>>> rtl/brp_stream_if.sv
// Valid/ready channel interfaces for incoming rows and emitted rows.
// Depends on brp_pkg for field widths.
interface brp_row_if;
    logic                          valid;
    logic                          ready;
    logic [brp_pkg::WORD_W-1:0]    row_brand;
    logic [brp_pkg::WORD_W-1:0]    row_container;
    logic [brp_pkg::WORD_W-1:0]    row_quantity;
    logic [brp_pkg::WORD_W-1:0]    row_price;
    logic [brp_pkg::DISC_W-1:0]    row_discount;
    logic                          chunk_end;

    modport source (output valid, row_brand, row_container, row_quantity, row_price,
                    row_discount, chunk_end, input ready);
    modport sink (input valid, row_brand, row_container, row_quantity, row_price,
                  row_discount, chunk_end, output ready);
endinterface

interface brp_res_if;
    logic                          valid;
    logic                          ready;
    logic [brp_pkg::WORD_W-1:0]    out_brand;
    logic [brp_pkg::WORD_W-1:0]    out_container;
    logic [brp_pkg::WORD_W-1:0]    out_quantity;
    logic [brp_pkg::WORD_W-1:0]    out_price;
    logic [brp_pkg::DISC_W-1:0]    out_discount;
    logic                          from_match_group;
    logic                          last_of_run;

    modport source (output valid, out_brand, out_container, out_quantity, out_price,
                    out_discount, from_match_group, last_of_run, input ready);
    modport sink (input valid, out_brand, out_container, out_quantity, out_price,
                  out_discount, from_match_group, last_of_run, output ready);
endinterface

>>> rtl/brp_cfg_regs.sv
// APB-style register file holding the match brand.
// Depends on brp_pkg.
module brp_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  brp_pkg::apb_addr_t paddr,
    input  brp_pkg::word_t     pwdata,
    output brp_pkg::word_t     prdata,
    output logic               pready,
    output brp_pkg::word_t     match_brand
);
    import brp_pkg::*;

    word_t match_brand_reg;
    word_t match_brand_next;
    logic  wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == REG_MATCH_BRAND);

    always_comb
    begin
        match_brand_next = wr_hit ? pwdata : match_brand_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_brand_reg <= '0;
        end
        else
        begin
            match_brand_reg <= match_brand_next;
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_MATCH_BRAND: prdata = match_brand_reg;
            default:         prdata = '0;
        endcase
    end

    assign match_brand = match_brand_reg;

endmodule

>>> rtl/brp_row_mem.sv
// Row store for both buffers: matching rows in the lower half, others in
// the upper half. One write and one registered read port. Depends on brp_pkg.
module brp_row_mem (
    input  logic              clk,
    input  brp_pkg::mem_ctl_t ctl,
    input  brp_pkg::row_t     wr_row,
    output brp_pkg::row_t     rd_row
);
    import brp_pkg::*;

    localparam int DEPTH = 2 * SIDE_SLOTS;

    row_t mem [DEPTH];
    row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_row_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

>>> rtl/brp_drain_seq.sv
// Sequencer: routes each row to a buffer slot, keeps the fill counts and
// walks the drain plan one row at a time. Depends on brp_pkg and the assert header.
`include "buffered_two_way_row_partition_assert.svh"

module brp_drain_seq #(
    parameter int GROUP_BUFFER_ROWS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  brp_pkg::word_t    in_brand,
    input  logic              in_chunk_end,
    input  brp_pkg::word_t    match_brand,
    input  logic              out_free,
    output brp_pkg::mem_ctl_t mem_ctl,
    output brp_pkg::out_ctl_t out_ctl
);
    import brp_pkg::*;

    localparam cnt_t CAP = cnt_t'(GROUP_BUFFER_ROWS);

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;
    cnt_t   match_fill_reg, match_fill_next;
    cnt_t   other_fill_reg, other_fill_next;
    logic   first_match_reg, first_match_next;
    cnt_t   first_cnt_reg, first_cnt_next;
    cnt_t   second_cnt_reg, second_cnt_next;
    logic   in_second_reg, in_second_next;

    logic   accept;
    logic   hit;
    cnt_t   mine_fill;
    cnt_t   fill_new;
    logic   full;
    cnt_t   mc, oc;
    logic   p_first_match;
    cnt_t   p_first_cnt;
    cnt_t   p_second_cnt;
    logic   cur_match;
    cnt_t   cur_cnt;
    cnt_t   idx_ext;
    logic   seg_done;
    logic   more;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign hit       = (in_brand == match_brand);
    assign mine_fill = hit ? match_fill_reg : other_fill_reg;
    assign fill_new  = mine_fill + cnt_t'(1);
    assign full      = (fill_new >= CAP);
    assign mc        = hit ? fill_new : match_fill_reg;
    assign oc        = hit ? other_fill_reg : fill_new;

    assign cur_match = in_second_reg ? !first_match_reg : first_match_reg;
    assign cur_cnt   = in_second_reg ? second_cnt_reg : first_cnt_reg;
    assign idx_ext   = {1'b0, idx_reg};
    assign seg_done  = (idx_ext + cnt_t'(1)) == cur_cnt;
    assign more      = !in_second_reg && (second_cnt_reg != '0);

    // Drain plan: at most two runs, the second from the opposite buffer
    always_comb
    begin
        p_first_match = hit;
        p_first_cnt   = '0;
        p_second_cnt  = '0;
        if (full)
        begin
            p_first_cnt  = CAP;
            p_second_cnt = in_chunk_end ? (hit ? other_fill_reg : match_fill_reg) : '0;
        end
        else if (in_chunk_end)
        begin
            if (mc != '0)
            begin
                p_first_match = 1'b1;
                p_first_cnt   = mc;
                p_second_cnt  = oc;
            end
            else
            begin
                p_first_match = 1'b0;
                p_first_cnt   = oc;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (p_first_cnt != '0))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = (seg_done && !more) ? ST_IDLE : ST_ISSUE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_comb
    begin
        idx_next         = idx_reg;
        match_fill_next  = match_fill_reg;
        other_fill_next  = other_fill_reg;
        first_match_next = first_match_reg;
        first_cnt_next   = first_cnt_reg;
        second_cnt_next  = second_cnt_reg;
        in_second_next   = in_second_reg;
        if (accept)
        begin
            idx_next         = '0;
            in_second_next   = 1'b0;
            first_match_next = p_first_match;
            first_cnt_next   = p_first_cnt;
            second_cnt_next  = p_second_cnt;
            if (hit)
            begin
                match_fill_next = full ? '0 : fill_new;
            end
            else
            begin
                other_fill_next = full ? '0 : fill_new;
            end
            if (in_chunk_end)
            begin
                match_fill_next = '0;
                other_fill_next = '0;
            end
        end
        else if (state_reg == ST_LOAD)
        begin
            if (seg_done)
            begin
                idx_next       = '0;
                in_second_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + idx_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            match_fill_reg  <= '0;
            other_fill_reg  <= '0;
            first_match_reg <= 1'b0;
            first_cnt_reg   <= '0;
            second_cnt_reg  <= '0;
            in_second_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            match_fill_reg  <= match_fill_next;
            other_fill_reg  <= other_fill_next;
            first_match_reg <= first_match_next;
            first_cnt_reg   <= first_cnt_next;
            second_cnt_reg  <= second_cnt_next;
            in_second_reg   <= in_second_next;
        end
    end

    // Outputs
    always_comb
    begin
        in_ready           = (state_reg == ST_IDLE);
        mem_ctl.wr_en      = accept;
        mem_ctl.wr_addr    = {!hit, mine_fill[IDX_W-1:0]};
        mem_ctl.rd_en      = (state_reg == ST_ISSUE) && out_free;
        mem_ctl.rd_addr    = {!cur_match, idx_reg};
        out_ctl.load       = (state_reg == ST_LOAD);
        out_ctl.last       = seg_done && !more;
        out_ctl.from_match = cur_match;
    end

    `BRP_ASSERT_ALWAYS(a_match_fill_below_cap, match_fill_reg < CAP, "match fill reached capacity")
    `BRP_ASSERT_ALWAYS(a_other_fill_below_cap, other_fill_reg < CAP, "other fill reached capacity")
    `BRP_ASSERT_SAME(a_idx_in_run, state_reg == ST_LOAD, idx_ext < cur_cnt, "drain index past run")

endmodule

>>> rtl/buffered_two_way_row_partition.sv
// Buffered two-way row partition. Each accepted row is compared with the
// match brand and written into the matching or the non-matching buffer
// (GROUP_BUFFER_ROWS rows each). A row that fills its buffer makes that
// buffer emit all its rows in arrival order; a row flagged as chunk end then
// makes the matching and after it the non-matching buffer emit what they
// hold, or, if it filled its buffer, that buffer first and then the other.
// The final row emitted for an input item carries last_of_run. While rows
// are emitted, the block takes no new row, since every emitted row goes
// through one read of the shared row memory and then one load of the output
// register, under one small sequencer; an output stall holds the drain. The
// output register lets the next row be accepted while the final result
// still waits to be taken. match_brand is at byte address 0 of the APB port
// and may only be written while idle.
// Depends on brp_pkg, brp_stream_if, the submodules and the assert header.
`include "buffered_two_way_row_partition_assert.svh"

module buffered_two_way_row_partition #(
    parameter int GROUP_BUFFER_ROWS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    brp_row_if.sink            rows,
    brp_res_if.source          results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  brp_pkg::apb_addr_t paddr,
    input  brp_pkg::word_t     pwdata,
    output brp_pkg::word_t     prdata,
    output logic               pready
);
    import brp_pkg::*;

    word_t    match_brand;
    mem_ctl_t mem_ctl;
    out_ctl_t out_ctl;
    row_t     wr_row;
    row_t     rd_row;
    logic     out_free;

    // Output register: holds one emitted row until taken
    logic     out_valid_reg, out_valid_next;
    row_t     out_row_reg, out_row_next;
    logic     out_match_reg, out_match_next;
    logic     out_last_reg, out_last_next;

    brp_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .match_brand (match_brand)
    );

    // Pack the incoming row for the store
    assign wr_row.brand     = rows.row_brand;
    assign wr_row.container = rows.row_container;
    assign wr_row.quantity  = rows.row_quantity;
    assign wr_row.price     = rows.row_price;
    assign wr_row.discount  = rows.row_discount;

    brp_row_mem u_mem (
        .clk    (clk),
        .ctl    (mem_ctl),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

    // Issue a read only when the output register will be free at load time
    assign out_free = !out_valid_reg || results.ready;

    brp_drain_seq #(
        .GROUP_BUFFER_ROWS (GROUP_BUFFER_ROWS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (rows.valid),
        .in_ready     (rows.ready),
        .in_brand     (rows.row_brand),
        .in_chunk_end (rows.chunk_end),
        .match_brand  (match_brand),
        .out_free     (out_free),
        .mem_ctl      (mem_ctl),
        .out_ctl      (out_ctl)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_match_next = out_match_reg;
        out_last_next  = out_last_reg;
        if (out_ctl.load)
        begin
            out_valid_next = 1'b1;
            out_row_next   = rd_row;
            out_match_next = out_ctl.from_match;
            out_last_next  = out_ctl.last;
        end
        else if (results.ready)
        begin
            // drop the row once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_match_reg <= out_match_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.out_brand        = out_row_reg.brand;
    assign results.out_container    = out_row_reg.container;
    assign results.out_quantity     = out_row_reg.quantity;
    assign results.out_price        = out_row_reg.price;
    assign results.out_discount     = out_row_reg.discount;
    assign results.from_match_group = out_match_reg;
    assign results.last_of_run      = out_last_reg;

    `BRP_ASSERT_SAME(a_load_into_free, out_ctl.load, !out_valid_reg, "output row overwritten")
    `BRP_ASSERT_NEXT(a_chunk_end_drains, rows.valid && rows.ready && rows.chunk_end,
                     !rows.ready, "chunk end emitted nothing")
    `BRP_ASSERT_NEXT(a_last_frees_input, out_ctl.load && out_ctl.last,
                     rows.ready, "input not freed after last row")

endmodule
